### design/atcl_pkg.sv
// ---------------------------------------------------------------------------
// atcl_pkg: shared types and constants of the AT command line tokenizer
// Holds the line and argument limits, character codes and payload structs.
// ---------------------------------------------------------------------------
`default_nettype none
package atcl_pkg;

  localparam int LINE_MAX = 32;
  localparam int MAX_ARGS = 8;
  localparam int AW       = $clog2(LINE_MAX);
  localparam int CW       = $clog2(LINE_MAX + 1);

  localparam logic [CW-1:0] LINE_MAX_C = CW'(LINE_MAX);
  localparam logic [3:0]    MAX_ARGS_C = 4'(MAX_ARGS);

  localparam logic [7:0] CH_EQUALS = 8'h3d;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_LF     = 8'h0a;

  localparam logic CFG_STOP = 1'b0;
  localparam logic CFG_SEP  = 1'b1;

  typedef struct packed {
    logic [7:0] char_in;
    logic       is_end;
  } in_t;

  typedef struct packed {
    logic [3:0] token_index;
    logic [7:0] char_value;
    logic       char_valid;
    logic       end_of_token;
    logic       end_of_line;
    logic [3:0] arg_count;
    logic       line_empty;
  } out_t;

endpackage
`default_nettype wire

### design/atcl_ram.sv
// ---------------------------------------------------------------------------
// atcl_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module atcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

### design/at_command_line_tokenizer_top.sv
// ---------------------------------------------------------------------------
// at_command_line_tokenizer_top: AT command line tokenizer
// Splits a command line into a command token and buffered argument tokens,
// quoted ones unescaped, at most one tagged character per result transfer.
// ---------------------------------------------------------------------------
// A plain character's result sits in the output register the cycle after
//   its transfer.
// Flush: an argument flush walks the argument buffer through its single
//   read port; input is stalled until the flush is done.
// Reset: rst_n synchronous, active low; stop and separator registers return to '=' and ','.
// ---------------------------------------------------------------------------
`default_nettype none
module at_command_line_tokenizer_top (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire atcl_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output atcl_pkg::out_t      out_data,
  input  wire logic           cfg_we,
  input  wire logic           cfg_index,
  input  wire logic [7:0]     cfg_wdata
);

  localparam logic [1:0] PH_SKIP = 2'd0;
  localparam logic [1:0] PH_CMD  = 2'd1;
  localparam logic [1:0] PH_ARGS = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SUM  = 4'd1;
  localparam logic [3:0] S_F1   = 4'd2;
  localparam logic [3:0] S_F1E  = 4'd3;
  localparam logic [3:0] S_F2   = 4'd4;
  localparam logic [3:0] S_F2E  = 4'd5;
  localparam logic [3:0] S_F3   = 4'd6;
  localparam logic [3:0] S_F3E  = 4'd7;
  localparam logic [3:0] S_F4E  = 4'd8;
  localparam logic [3:0] S_RAW  = 4'd9;
  localparam logic [3:0] S_RAWE = 4'd10;
  localparam logic [3:0] S_EOT  = 4'd11;

  localparam int CW = atcl_pkg::CW;
  localparam int AW = atcl_pkg::AW;

  logic [3:0]    state_r, state_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] last_r, last_nxt;
  logic          inq_r, inq_nxt;
  logic          esc_r, esc_nxt;
  logic          eol_r, eol_nxt;
  logic [3:0]    args_r, args_nxt;
  logic [7:0]    stop_r, sep_r;
  logic          out_valid_r, out_valid_nxt;
  atcl_pkg::out_t out_data_r, out_data_nxt;

  logic          accept, can_emit, emit;
  atcl_pkg::out_t emit_data;
  logic          ram_we;
  logic [CW-1:0] raddr;
  logic [7:0]    rdata, c;
  logic [3:0]    tok;

  function automatic atcl_pkg::out_t mk(input logic [3:0] ti, input logic [7:0] cv,
                                        input logic vld, input logic eot,
                                        input logic eol, input logic [3:0] cnt,
                                        input logic emp);
    atcl_pkg::out_t o;
    o.token_index  = ti;
    o.char_value   = cv;
    o.char_valid   = vld;
    o.end_of_token = eot;
    o.end_of_line  = eol;
    o.arg_count    = cnt;
    o.line_empty   = emp;
    return o;
  endfunction

  function automatic logic trim(input logic [7:0] ch, input logic [7:0] sep);
    return (ch == sep) || (ch == atcl_pkg::CH_SPACE);
  endfunction

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign can_emit  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign c         = in_data.char_in;
  assign tok       = args_r + 4'd1;

  atcl_ram #(.WIDTH(8), .DEPTH(atcl_pkg::LINE_MAX)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[AW-1:0]),
    .wdata (c),
    .raddr (raddr[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    fill_nxt  = fill_r;
    len_nxt   = len_r;
    ptr_nxt   = ptr_r;
    last_nxt  = last_r;
    inq_nxt   = inq_r;
    esc_nxt   = esc_r;
    eol_nxt   = eol_r;
    args_nxt  = args_r;
    emit      = 1'b0;
    emit_data = mk(4'd0, 8'd0, 1'b0, 1'b0, 1'b0, 4'd0, 1'b0);
    ram_we    = 1'b0;
    raddr     = ptr_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.is_end) begin
            unique case (phase_r)
              PH_SKIP: begin
                emit      = 1'b1;
                emit_data = mk(4'd0, 8'd0, 1'b0, 1'b0, 1'b1, 4'd0, 1'b1);
                len_nxt   = '0;
              end
              PH_CMD: begin
                emit      = 1'b1;
                emit_data = mk(4'd0, 8'd0, 1'b0, 1'b1, 1'b0, 4'd0, 1'b0);
                state_nxt = S_SUM;
              end
              PH_ARGS: begin
                eol_nxt   = 1'b1;
                ptr_nxt   = '0;
                state_nxt = S_F1;
              end
              default: begin
                emit      = 1'b1;
                emit_data = mk(4'd0, 8'd0, 1'b0, 1'b0, 1'b1, args_r, 1'b0);
                phase_nxt = PH_SKIP;
                len_nxt   = '0;
                args_nxt  = '0;
                fill_nxt  = '0;
                inq_nxt   = 1'b0;
                esc_nxt   = 1'b0;
              end
            endcase
          end else if (len_r >= atcl_pkg::LINE_MAX_C) begin
            // drop characters past the line limit
          end else if (c == 8'd0) begin
            len_nxt = atcl_pkg::LINE_MAX_C;
          end else begin
            len_nxt = len_r + 1'b1;
            if (phase_r == PH_SKIP || phase_r == PH_CMD) begin
              if (phase_r == PH_SKIP &&
                  (c == atcl_pkg::CH_SPACE || c == atcl_pkg::CH_TAB)) begin
                // skip leading blank
              end else if (c == stop_r) begin
                phase_nxt = PH_ARGS;
                fill_nxt  = '0;
                inq_nxt   = 1'b0;
                esc_nxt   = 1'b0;
                emit      = 1'b1;
                emit_data = mk(4'd0, 8'd0, 1'b0, 1'b1, 1'b0, 4'd0, 1'b0);
              end else begin
                phase_nxt = PH_CMD;
                emit      = 1'b1;
                emit_data = mk(4'd0, c, 1'b1, 1'b0, 1'b0, 4'd0, 1'b0);
              end
            end else if (phase_r == PH_ARGS) begin
              if (sep_r == atcl_pkg::CH_SPACE && fill_r == '0 &&
                  (c == atcl_pkg::CH_SPACE || c == atcl_pkg::CH_TAB)) begin
                // skip blank run at argument start when the separator is a space
              end else if (c == sep_r && !inq_r) begin
                eol_nxt   = 1'b0;
                ptr_nxt   = '0;
                state_nxt = S_F1;
              end else begin
                if (c == atcl_pkg::CH_QUOTE && !esc_r) begin
                  inq_nxt = !inq_r;
                end
                esc_nxt = (c == atcl_pkg::CH_BSLASH);
                if (fill_r < atcl_pkg::LINE_MAX_C) begin
                  ram_we   = 1'b1;
                  fill_nxt = fill_r + 1'b1;
                end
              end
            end
          end
        end
      end
      S_F1: begin
        if (ptr_r < fill_r) begin
          state_nxt = S_F1E;
        end else begin
          ptr_nxt   = '0;
          state_nxt = S_RAW;
        end
      end
      S_F1E: begin
        if (trim(rdata, sep_r)) begin
          ptr_nxt   = ptr_r + 1'b1;
          state_nxt = S_F1;
        end else if (rdata == atcl_pkg::CH_QUOTE) begin
          last_nxt  = fill_r - 1'b1;
          state_nxt = S_F2;
        end else begin
          ptr_nxt   = '0;
          state_nxt = S_RAW;
        end
      end
      S_F2: begin
        raddr = last_r;
        state_nxt = (last_r > ptr_r) ? S_F2E : S_EOT;
      end
      S_F2E: begin
        raddr = last_r;
        if (trim(rdata, sep_r)) begin
          last_nxt  = last_r - 1'b1;
          state_nxt = S_F2;
        end else if (rdata == atcl_pkg::CH_QUOTE) begin
          ptr_nxt   = ptr_r + 1'b1;
          state_nxt = S_F3;
        end else begin
          state_nxt = S_EOT;
        end
      end
      S_F3: begin
        state_nxt = (ptr_r < last_r) ? S_F3E : S_EOT;
      end
      S_F3E: begin
        if (rdata == atcl_pkg::CH_BSLASH) begin
          raddr     = ptr_r + 1'b1;
          state_nxt = S_F4E;
        end else if (can_emit) begin
          emit      = 1'b1;
          emit_data = mk(tok, rdata, 1'b1, 1'b0, 1'b0, 4'd0, 1'b0);
          ptr_nxt   = ptr_r + 1'b1;
          state_nxt = S_F3;
        end
      end
      S_F4E: begin
        raddr = ptr_r + 1'b1;
        if (can_emit) begin
          if (rdata == atcl_pkg::CH_QUOTE || rdata == atcl_pkg::CH_BSLASH) begin
            emit      = 1'b1;
            emit_data = mk(tok, rdata, 1'b1, 1'b0, 1'b0, 4'd0, 1'b0);
          end else if (rdata == atcl_pkg::CH_N) begin
            emit      = 1'b1;
            emit_data = mk(tok, atcl_pkg::CH_LF, 1'b1, 1'b0, 1'b0, 4'd0, 1'b0);
          end else if (rdata == atcl_pkg::CH_T) begin
            emit      = 1'b1;
            emit_data = mk(tok, atcl_pkg::CH_TAB, 1'b1, 1'b0, 1'b0, 4'd0, 1'b0);
          end
          ptr_nxt   = ptr_r + CW'(2);
          state_nxt = S_F3;
        end
      end
      S_RAW: begin
        state_nxt = (ptr_r < fill_r) ? S_RAWE : S_EOT;
      end
      S_RAWE: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_data = mk(tok, rdata, 1'b1, 1'b0, 1'b0, 4'd0, 1'b0);
          ptr_nxt   = ptr_r + 1'b1;
          state_nxt = S_RAW;
        end
      end
      S_EOT: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_data = mk(tok, 8'd0, 1'b0, 1'b1, 1'b0, 4'd0, 1'b0);
          args_nxt  = tok;
          fill_nxt  = '0;
          inq_nxt   = 1'b0;
          esc_nxt   = 1'b0;
          ptr_nxt   = '0;
          if (eol_r) begin
            state_nxt = S_SUM;
          end else begin
            if (tok >= atcl_pkg::MAX_ARGS_C) begin
              phase_nxt = PH_DONE;
            end
            state_nxt = S_IDLE;
          end
        end
      end
      S_SUM: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_data = mk(4'd0, 8'd0, 1'b0, 1'b0, 1'b1, args_r, 1'b0);
          phase_nxt = PH_SKIP;
          len_nxt   = '0;
          args_nxt  = '0;
          fill_nxt  = '0;
          inq_nxt   = 1'b0;
          esc_nxt   = 1'b0;
          eol_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_data;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
      out_data_nxt  = out_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_SKIP;
      fill_r      <= '0;
      len_r       <= '0;
      ptr_r       <= '0;
      last_r      <= '0;
      inq_r       <= 1'b0;
      esc_r       <= 1'b0;
      eol_r       <= 1'b0;
      args_r      <= '0;
      out_valid_r <= 1'b0;
      stop_r      <= atcl_pkg::CH_EQUALS;
      sep_r       <= atcl_pkg::CH_COMMA;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      fill_r      <= fill_nxt;
      len_r       <= len_nxt;
      ptr_r       <= ptr_nxt;
      last_r      <= last_nxt;
      inq_r       <= inq_nxt;
      esc_r       <= esc_nxt;
      eol_r       <= eol_nxt;
      args_r      <= args_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          atcl_pkg::CFG_STOP: stop_r <= cfg_wdata;
          atcl_pkg::CFG_SEP:  sep_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= atcl_pkg::LINE_MAX_C)
    else $error("argument buffer fill beyond line limit");

  a_ptr_in_buf: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_SUM) |-> ptr_r <= fill_r)
    else $error("flush pointer beyond buffer fill");

  a_tok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.token_index <= atcl_pkg::MAX_ARGS_C)
    else $error("token index beyond argument limit");

  a_sum_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.end_of_line) |-> (phase_r == PH_SKIP && args_r == '0))
    else $error("line state not cleared after summary");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input taken during flush");

endmodule
`default_nettype wire

### bench/tb_at_command_line_tokenizer_top.sv
// ---------------------------------------------------------------------------
// tb_at_command_line_tokenizer_top: self-checking bench of the line tokenizer
// Drives directed and random command lines under random idling and a long
// result hold-off, predicts every token transfer and checks them in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

class token_scoreboard;
  atcl_pkg::out_t tokens_due[$];
  int             errors;
  int             checked;
  int             lines_done;
  logic [7:0]     stop_char;
  logic [7:0]     sep_char;
  logic [7:0]     arg_buf[atcl_pkg::LINE_MAX];
  int             buf_fill;
  int             line_len;
  int             phase;   // 0 skip, 1 command, 2 arguments, 3 done
  bit             quoted;
  bit             escaped;
  logic [3:0]     args_done;

  function new();
    stop_char = atcl_pkg::CH_EQUALS;
    sep_char  = atcl_pkg::CH_COMMA;
    clear_line();
  endfunction

  function void clear_line();
    buf_fill  = 0;
    quoted    = 0;
    escaped   = 0;
    line_len  = 0;
    phase     = 0;
    args_done = 0;
  endfunction

  function void push_token(logic [3:0] tok, logic [7:0] ch, logic vld, logic eot,
                           logic eol, logic [3:0] cnt, logic emp);
    atcl_pkg::out_t r;
    r.token_index  = tok;
    r.char_value   = ch;
    r.char_valid   = vld;
    r.end_of_token = eot;
    r.end_of_line  = eol;
    r.arg_count    = cnt;
    r.line_empty   = emp;
    tokens_due.push_back(r);
  endfunction

  function bit trims(logic [7:0] c);
    return c == sep_char || c == atcl_pkg::CH_SPACE;
  endfunction

  function void flush_arg();
    logic [3:0] tok;
    int         first;
    int         last;
    int         i;
    logic [7:0] c;
    logic [7:0] d;
    tok   = args_done + 4'd1;
    first = 0;
    while (first < buf_fill && trims(arg_buf[first])) first++;
    if (first < buf_fill && arg_buf[first] == atcl_pkg::CH_QUOTE) begin
      last = buf_fill - 1;
      while (last > first && trims(arg_buf[last])) last--;
      if (last > first && arg_buf[last] == atcl_pkg::CH_QUOTE) begin
        i = first + 1;
        while (i < last) begin
          c = arg_buf[i];
          if (c == atcl_pkg::CH_BSLASH) begin
            d = arg_buf[i+1];
            if (d == atcl_pkg::CH_QUOTE || d == atcl_pkg::CH_BSLASH)
              push_token(tok, d, 1, 0, 0, 0, 0);
            else if (d == atcl_pkg::CH_N)
              push_token(tok, atcl_pkg::CH_LF, 1, 0, 0, 0, 0);
            else if (d == atcl_pkg::CH_T)
              push_token(tok, atcl_pkg::CH_TAB, 1, 0, 0, 0, 0);
            i += 2;
          end else begin
            push_token(tok, c, 1, 0, 0, 0, 0);
            i++;
          end
        end
      end
    end else begin
      for (i = 0; i < buf_fill; i++) push_token(tok, arg_buf[i], 1, 0, 0, 0, 0);
    end
    push_token(tok, 8'h00, 0, 1, 0, 0, 0);
    args_done = args_done + 4'd1;
    buf_fill = 0;
    quoted   = 0;
    escaped  = 0;
  endfunction

  function void note_char(atcl_pkg::in_t it);
    logic [7:0] c;
    c = it.char_in;
    if (it.is_end) begin
      if (phase == 0) begin
        push_token(0, 0, 0, 0, 1, 0, 1);
      end else begin
        if (phase == 1) push_token(0, 0, 0, 1, 0, 0, 0);
        else if (phase == 2) flush_arg();
        push_token(0, 0, 0, 0, 1, args_done, 0);
      end
      lines_done++;
      clear_line();
      return;
    end
    if (line_len >= atcl_pkg::LINE_MAX) return;
    if (c == 8'h00) begin
      line_len = atcl_pkg::LINE_MAX;
      return;
    end
    line_len++;
    if (phase == 0) begin
      if (c == atcl_pkg::CH_SPACE || c == atcl_pkg::CH_TAB) return;
      phase = 1;
    end
    if (phase == 1) begin
      if (c == stop_char) begin
        phase    = 2;
        buf_fill = 0;
        quoted   = 0;
        escaped  = 0;
        push_token(0, 0, 0, 1, 0, 0, 0);
      end else begin
        push_token(0, c, 1, 0, 0, 0, 0);
      end
      return;
    end
    if (phase == 2) begin
      if (sep_char == atcl_pkg::CH_SPACE && buf_fill == 0 &&
          (c == atcl_pkg::CH_SPACE || c == atcl_pkg::CH_TAB)) return;
      if (c == sep_char && !quoted) begin
        flush_arg();
        if (args_done >= atcl_pkg::MAX_ARGS_C) phase = 3;
        return;
      end
      if (c == atcl_pkg::CH_QUOTE && !escaped) quoted = !quoted;
      escaped = (c == atcl_pkg::CH_BSLASH);
      if (buf_fill < atcl_pkg::LINE_MAX) begin
        arg_buf[buf_fill] = c;
        buf_fill++;
      end
    end
  endfunction

  function void check_token(atcl_pkg::out_t got);
    atcl_pkg::out_t want;
    if (tokens_due.size() == 0) begin
      $error("unexpected token transfer %h", got);
      errors++;
      return;
    end
    want = tokens_due.pop_front();
    checked++;
    if (got.token_index !== want.token_index) begin
      $error("token_index expected %0d actual %0d", want.token_index, got.token_index);
      errors++;
    end
    if (got.char_value !== want.char_value) begin
      $error("char_value expected %h actual %h", want.char_value, got.char_value);
      errors++;
    end
    if (got.char_valid !== want.char_valid) begin
      $error("char_valid expected %b actual %b", want.char_valid, got.char_valid);
      errors++;
    end
    if (got.end_of_token !== want.end_of_token) begin
      $error("end_of_token expected %b actual %b", want.end_of_token, got.end_of_token);
      errors++;
    end
    if (got.end_of_line !== want.end_of_line) begin
      $error("end_of_line expected %b actual %b", want.end_of_line, got.end_of_line);
      errors++;
    end
    if (got.arg_count !== want.arg_count) begin
      $error("arg_count expected %0d actual %0d", want.arg_count, got.arg_count);
      errors++;
    end
    if (got.line_empty !== want.line_empty) begin
      $error("line_empty expected %b actual %b", want.line_empty, got.line_empty);
      errors++;
    end
  endfunction
endclass

module tb_at_command_line_tokenizer_top;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  atcl_pkg::in_t  in_data;
  logic out_valid;
  logic out_stall;
  atcl_pkg::out_t out_data;
  logic cfg_we;
  logic cfg_index;
  logic [7:0] cfg_wdata;

  token_scoreboard sb;
  bit quiet_in;
  bit quiet_out;
  int hold_off;
  int chars_sent;

  at_command_line_tokenizer_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  // result side: random stall plus a counted long hold-off
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_token(out_data);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1;
    end else begin
      out_stall <= quiet_out ? 1'b0 : ($urandom_range(99) < 30);
    end
  end

  // valid stays high between back-to-back transfers; drain() drops it
  task send_char(logic [7:0] c, logic e);
    atcl_pkg::in_t it;
    it.char_in = c;
    it.is_end  = e;
    while (!quiet_in && $urandom_range(99) < 30) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_char(it);
    chars_sent++;
  endtask

  task send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 0);
    send_char($urandom, 1);
  endtask

  task drain();
    int n;
    n = 0;
    in_valid <= 0;
    while (sb.tokens_due.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (200) @(posedge clk);
  endtask

  task write_reg(logic idx, logic [7:0] v);
    drain();
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == atcl_pkg::CFG_STOP) sb.stop_char = v;
    else sb.sep_char = v;
  endtask

  function logic [7:0] pick_char();
    case ($urandom_range(11))
      0: return sb.stop_char;
      1, 2: return sb.sep_char;
      3: return atcl_pkg::CH_QUOTE;
      4: return atcl_pkg::CH_BSLASH;
      5: return atcl_pkg::CH_SPACE;
      6: return atcl_pkg::CH_TAB;
      7: return atcl_pkg::CH_N;
      8: return ($urandom_range(30) == 0) ? 8'h00 : atcl_pkg::CH_T;
      default: return $urandom_range(255);
    endcase
  endfunction

  task random_line();
    int len;
    len = ($urandom_range(9) == 0) ? $urandom_range(34, 40) : $urandom_range(0, 14);
    if ($urandom_range(3) != 0) begin
      // well-formed: command, stop char, then mixed arguments
      send_char($urandom_range(65, 90), 0);
      send_char(sb.stop_char, 0);
      len = len > 2 ? len - 2 : 0;
    end
    for (int i = 0; i < len; i++) send_char(pick_char(), 0);
    send_char($urandom, 1);
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_wdata = 0;
    quiet_in = 0;
    quiet_out = 0;
    hold_off = 0;
    chars_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed lines: blanks, quoting, escapes, too many args, long line
    send_text("  \t ");
    send_text("ATZ");
    send_text("AT=\"a\\\"b\\\\c\\nd\\te\\q\" , x,");
    send_text("C=\"open,1,2,3,4,5,6,7,8,9");
    send_text("X=1,2,3,4,5,6,7,8,9");
    send_char(8'hff, 0);
    send_char(8'h00, 0);
    send_char(8'h41, 1);
    send_text("L=0123456789abcdef0123456789abcdef");

    // fill the block while results are held off
    hold_off <= 300;
    send_text("H=abc,defgh,\"ij\",k");

    write_reg(atcl_pkg::CFG_STOP, 8'h00);
    write_reg(atcl_pkg::CFG_SEP, 8'hff);
    send_text("a=b");
    write_reg(atcl_pkg::CFG_STOP, 8'hff);
    write_reg(atcl_pkg::CFG_SEP, atcl_pkg::CH_SPACE);
    send_char(8'h41, 0); send_char(8'hff, 0);
    send_text("   a  \" q \"  b");
    write_reg(atcl_pkg::CFG_STOP, atcl_pkg::CH_EQUALS);
    write_reg(atcl_pkg::CFG_SEP, atcl_pkg::CH_COMMA);

    quiet_in = 1;
    quiet_out = 1;
    repeat (3) random_line();
    quiet_in = 0;
    quiet_out = 0;
    while (chars_sent < 195) random_line();
    write_reg(atcl_pkg::CFG_STOP, atcl_pkg::CH_QUOTE);
    write_reg(atcl_pkg::CFG_SEP, atcl_pkg::CH_SPACE);
    while (chars_sent < 210) random_line();
    write_reg(atcl_pkg::CFG_STOP, $urandom);
    write_reg(atcl_pkg::CFG_SEP, $urandom);
    while (chars_sent < 225) random_line();

    drain();
    if (sb.tokens_due.size() != 0) begin
      $error("%0d token transfers never arrived", sb.tokens_due.size());
      sb.errors++;
    end
    $display("Ran %0d characters over %0d lines, %0d token transfers checked,",
             chars_sent, sb.lines_done, sb.checked);
    $display("under several stop and separator settings with a long result hold-off.");
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

### sim.f
design/atcl_pkg.sv
design/atcl_ram.sv
design/at_command_line_tokenizer_top.sv
bench/tb_at_command_line_tokenizer_top.sv
